// File: hdl/i2c_master_bit_engine_assert.svh
// Assertion macros shared by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define I2CM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent follows from an antecedent in the same cycle.
`define I2CM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent follows in the cycle after an antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/i2cm_pkg.sv
// Types, codes and constants of the I2C master bit engine.
package i2cm_pkg;

  // Queue between the command decoder and the bit sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values and byte framing.
  localparam logic [7:0]  HALF_BIT_RESET = 8'd5;
  localparam logic [15:0] STRETCH_RESET  = 16'd1000;
  localparam logic [3:0]  BYTE_BITS      = 4'd8;
  localparam logic [3:0]  LAST_DATA_BIT  = 4'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_BIT_TICKS = 4'd0,
    CFG_STRETCH_LIMIT  = 4'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RS_SETUP   = 4'd1,
    PH_RS_STRETCH = 4'd2,
    PH_RS_HOLD    = 4'd3,
    PH_ST_FALL    = 4'd4,
    PH_SP_SETUP   = 4'd5,
    PH_SP_STRETCH = 4'd6,
    PH_SP_HOLD    = 4'd7,
    PH_SP_RISE    = 4'd8,
    PH_SP_TAIL    = 4'd9,
    PH_B_SETUP    = 4'd10,
    PH_B_STRETCH  = 4'd11,
    PH_B_HOLD     = 4'd12
  } phase_e;

  typedef struct packed {
    logic [7:0]  half_bit_ticks;
    logic [15:0] stretch_limit;
  } cfg_t;

  // One decoded tick as it waits in the queue.
  typedef struct packed {
    req_e       cmd;
    logic [7:0] write_data;
    logic       ack_enable;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       arb_lost;
    logic       bus_started;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

// File: hdl/i2cm_if.sv
// Handshake interfaces of the I2C master bit engine: tick, result and configuration.
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] write_data;
  logic       ack_enable;
  logic       scl_in;
  logic       sda_in;

  modport source (output valid, req_type, write_data, ack_enable, scl_in, sda_in,
                  input ready);
  modport sink   (input valid, req_type, write_data, ack_enable, scl_in, sda_in,
                  output ready);
endinterface

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_seen;
  logic       arb_lost;
  logic       bus_started;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, read_data,
                         ack_seen, arb_lost, bus_started,
                  input ready);
  modport sink   (input valid, scl_release, sda_release, busy_res, done_res, read_data,
                        ack_seen, arb_lost, bus_started,
                  output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/i2cm_front.sv
// Front end: accepts tick items and classifies their request codes.
module i2cm_front import i2cm_pkg::*; (
  i2cm_req_if.sink req_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output item_t    item_o
);

  req_e cmd;

  // Unused request codes behave as a plain tick.
  always_comb begin
    unique case (req_i.req_type)
      REQ_START: cmd = REQ_START;
      REQ_STOP:  cmd = REQ_STOP;
      REQ_WRITE: cmd = REQ_WRITE;
      REQ_READ:  cmd = REQ_READ;
      default:   cmd = REQ_TICK;
    endcase
  end

  // The front stalls only when the queue has no free entry.
  assign req_i.ready = ~queue_full_i;
  assign push_o      = req_i.valid & ~queue_full_i;

  assign item_o.cmd        = cmd;
  assign item_o.write_data = req_i.write_data;
  assign item_o.ack_enable = req_i.ack_enable;
  assign item_o.scl_in     = req_i.scl_in;
  assign item_o.sda_in     = req_i.sda_in;

endmodule

// File: hdl/i2cm_queue.sv
// Short FIFO that decouples the command decoder from the bit sequencer.
module i2cm_queue import i2cm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t stat_o
);

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.count = count_q;

  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & stat_o.valid;

  // Pointers wrap at the depth and the count tracks the occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o = entry_q[rd_ptr_q];

endmodule

// File: hdl/i2cm_back.sv
// Back end: the bit sequencer that drives SCL and SDA, with its result register.
module i2cm_back import i2cm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  pop_o,
  i2cm_rsp_if.source rsp_o
);

  phase_e      phase_q, phase_d;
  req_e        cmd_q, cmd_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  delay_q, delay_d;
  logic [15:0] stretch_q, stretch_d;
  logic        started_q, started_d;
  logic        arb_q, arb_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [7:0]  recv_q, recv_d;
  logic        done;

  logic        advance;
  logic [7:0]  delay_inc;
  logic        delay_over;
  logic        stretch_over;
  logic [3:0]  bit_inc;
  logic        is_write;

  logic        out_valid_q;
  result_t     out_q, out_d;

  // A tick is executed when one is queued and the result slot is free or draining.
  assign advance = item_valid_i & (~out_valid_q | rsp_o.ready);
  assign pop_o   = advance;

  assign delay_inc    = delay_q + 8'd1;
  assign delay_over   = (delay_inc >= cfg_i.half_bit_ticks);
  assign stretch_over = item_i.scl_in | (stretch_q >= cfg_i.stretch_limit);
  assign bit_inc      = bit_cnt_q + 4'd1;
  assign is_write     = (cmd_q == REQ_WRITE);

  // Next state of the sequencer for one tick.
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    delay_d   = delay_q;
    stretch_d = stretch_q;
    started_d = started_q;
    arb_d     = arb_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    recv_d    = recv_q;
    done      = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (item_i.cmd != REQ_TICK) begin
          cmd_d     = item_i.cmd;
          arb_d     = 1'b0;
          delay_d   = '0;
          stretch_d = '0;
          case (item_i.cmd)
            REQ_START: begin
              if (started_q) begin
                sda_d   = 1'b1;
                phase_d = PH_RS_SETUP;
              end else begin
                if (!item_i.sda_in) begin
                  arb_d = 1'b1;
                end
                sda_d   = 1'b0;
                phase_d = PH_ST_FALL;
              end
            end
            REQ_STOP: begin
              sda_d   = 1'b0;
              phase_d = PH_SP_SETUP;
            end
            default: begin
              // Byte transfer starts with its first data bit.
              bit_cnt_d = '0;
              if (item_i.cmd == REQ_WRITE) begin
                shift_d = item_i.write_data;
                ack_d   = 1'b0;
                sda_d   = item_i.write_data[7];
              end else begin
                shift_d = '0;
                ack_d   = item_i.ack_enable;
                sda_d   = 1'b1;
              end
              phase_d = PH_B_SETUP;
            end
          endcase
        end
      end
      PH_RS_SETUP, PH_SP_SETUP, PH_B_SETUP: begin
        if (delay_over) begin
          delay_d = '0;
          scl_d   = 1'b1;
          phase_d = (phase_q == PH_RS_SETUP) ? PH_RS_STRETCH :
                    (phase_q == PH_SP_SETUP) ? PH_SP_STRETCH : PH_B_STRETCH;
        end else begin
          delay_d = delay_inc;
        end
      end
      PH_RS_STRETCH, PH_SP_STRETCH, PH_B_STRETCH: begin
        if (stretch_over) begin
          stretch_d = '0;
          phase_d   = (phase_q == PH_RS_STRETCH) ? PH_RS_HOLD :
                      (phase_q == PH_SP_STRETCH) ? PH_SP_HOLD : PH_B_HOLD;
        end else begin
          stretch_d = stretch_q + 16'd1;
        end
      end
      PH_RS_HOLD: begin
        if (delay_over) begin
          delay_d = '0;
          if (!item_i.sda_in) begin
            arb_d = 1'b1;
          end
          sda_d   = 1'b0;
          phase_d = PH_ST_FALL;
        end else begin
          delay_d = delay_inc;
        end
      end
      PH_ST_FALL: begin
        if (delay_over) begin
          delay_d   = '0;
          scl_d     = 1'b0;
          started_d = 1'b1;
          phase_d   = PH_IDLE;
          done      = 1'b1;
        end else begin
          delay_d = delay_inc;
        end
      end
      PH_SP_HOLD: begin
        if (delay_over) begin
          delay_d = '0;
          sda_d   = 1'b1;
          phase_d = PH_SP_RISE;
        end else begin
          delay_d = delay_inc;
        end
      end
      PH_SP_RISE: begin
        if (delay_over) begin
          delay_d = '0;
          if (!item_i.sda_in) begin
            arb_d = 1'b1;
          end
          phase_d = PH_SP_TAIL;
        end else begin
          delay_d = delay_inc;
        end
      end
      PH_SP_TAIL: begin
        if (delay_over) begin
          delay_d   = '0;
          started_d = 1'b0;
          phase_d   = PH_IDLE;
          done      = 1'b1;
        end else begin
          delay_d = delay_inc;
        end
      end
      PH_B_HOLD: begin
        if (delay_over) begin
          delay_d = '0;
          // Sample SDA with SCL high: data, arbitration or acknowledge.
          if (is_write) begin
            if (bit_cnt_q < BYTE_BITS) begin
              if (sda_q && !item_i.sda_in) begin
                arb_d = 1'b1;
              end
              shift_d = {shift_q[6:0], 1'b0};
            end else begin
              ack_d = ~item_i.sda_in & ~arb_q;
            end
          end else begin
            if (bit_cnt_q < BYTE_BITS) begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              if (bit_cnt_q == LAST_DATA_BIT) begin
                recv_d = {shift_q[6:0], item_i.sda_in};
              end
            end else if (sda_q && !item_i.sda_in) begin
              arb_d = 1'b1;
            end
          end
          scl_d = 1'b0;
          if (bit_cnt_q >= BYTE_BITS) begin
            bit_cnt_d = '0;
            phase_d   = PH_IDLE;
            done      = 1'b1;
          end else begin
            // Next bit: data MSB first, then the acknowledge slot.
            bit_cnt_d = bit_inc;
            phase_d   = PH_B_SETUP;
            if (bit_inc < BYTE_BITS) begin
              sda_d = is_write ? shift_d[7] : 1'b1;
            end else begin
              sda_d = is_write ? 1'b1 : ~ack_q;
            end
          end
        end else begin
          delay_d = delay_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Result of this tick, after the update.
  always_comb begin
    out_d.scl_release = scl_d;
    out_d.sda_release = sda_d;
    out_d.busy_res    = (phase_d != PH_IDLE);
    out_d.done_res    = done;
    out_d.read_data   = recv_d;
    out_d.ack_seen    = (cmd_d == REQ_WRITE) ? ack_d : 1'b0;
    out_d.arb_lost    = arb_d;
    out_d.bus_started = started_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cmd_q     <= REQ_TICK;
      bit_cnt_q <= '0;
      shift_q   <= '0;
      delay_q   <= '0;
      stretch_q <= '0;
      started_q <= 1'b0;
      arb_q     <= 1'b0;
      ack_q     <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      recv_q    <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      delay_q   <= delay_d;
      stretch_q <= stretch_d;
      started_q <= started_d;
      arb_q     <= arb_d;
      ack_q     <= ack_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      recv_q    <= recv_d;
    end
  end

  // Output register: filled on each executed tick, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.scl_release = out_q.scl_release;
  assign rsp_o.sda_release = out_q.sda_release;
  assign rsp_o.busy_res    = out_q.busy_res;
  assign rsp_o.done_res    = out_q.done_res;
  assign rsp_o.read_data   = out_q.read_data;
  assign rsp_o.ack_seen    = out_q.ack_seen;
  assign rsp_o.arb_lost    = out_q.arb_lost;
  assign rsp_o.bus_started = out_q.bus_started;

endmodule

// File: hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: decoder, queue, sequencer and registers.
//
// Use: every item on req_i is one timing tick with the sampled SCL and SDA
// levels and an optional command (start, stop, write byte, read byte). A
// command that arrives while a previous one is still running is dropped.
// Each tick yields exactly one item on rsp_o with the line drive values
// and status after that tick; the pins follow scl_release and sda_release.
// Throughput is one tick per cycle while rsp_o does not stall. An accepted
// tick is stored in the four-entry queue and then executed by the sequencer,
// whose registered result sits in a one-entry output stage.
// When rsp_o stalls, the output stage holds its item and the queue keeps
// taking ticks until it fills; then req_i.ready drops until space frees.
// cfg_i writes half_bit_ticks (index 0) and stretch_limit (index 1); it is
// always ready and must be used only while the engine is idle.
// Reset releases both lines, clears the bus state and the queue, and loads
// half_bit_ticks with 5 and stretch_limit with 1000.
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_req_if.sink   req_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_rsp_if.source rsp_o
);

  cfg_t   cfg_q, cfg_d;
  logic   push;
  logic   pop;
  item_t  front_item;
  item_t  queue_item;
  qstat_t q_stat;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == CFG_HALF_BIT_TICKS) begin
        cfg_d.half_bit_ticks = cfg_i.data[7:0];
      end else if (cfg_i.index == CFG_STRETCH_LIMIT) begin
        cfg_d.stretch_limit = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks <= HALF_BIT_RESET;
      cfg_q.stretch_limit  <= STRETCH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2cm_front u_front (
    .req_i        (req_i),
    .queue_full_i (q_stat.full),
    .push_o       (push),
    .item_o       (front_item)
  );

  i2cm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (q_stat)
  );

  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_stat.valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

  // A finished command never reports itself as still running.
  `I2CM_ASSERT_IMPL(a_done_not_busy, rsp_o.valid && rsp_o.done_res, !rsp_o.busy_res, "done with busy set")
  // The queue never holds more entries than it has.
  `I2CM_ASSERT(a_queue_bound, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overflow")
  // An accepted tick with no pop grows the queue by one entry.
  `I2CM_ASSERT_NEXT(a_queue_grow, req_i.valid && req_i.ready && !pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count mismatch")
  // The sequencer only executes a tick that is queued.
  `I2CM_ASSERT_IMPL(a_pop_valid, pop, q_stat.valid, "pop from empty queue")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the I2C master bit engine: directed and random ticks against a tick model.
module tb_top;
  import i2cm_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned PRINT_LIMIT     = 40;
  localparam logic [3:0]  CFG_UNUSED_IDX  = 4'd15;
  localparam logic [2:0]  REQ_SPARE_LO    = 3'd5;
  localparam logic [2:0]  REQ_SPARE_HI    = 3'd7;

  // One tick as it is offered to the engine.
  typedef struct packed {
    logic [2:0] code;
    logic [7:0] wdata;
    logic       acken;
    logic       scl;
    logic       sda;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  i2cm_req_if req_if ();
  i2cm_rsp_if rsp_if ();
  i2cm_cfg_if cfg_if ();

  i2c_master_bit_engine u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Engine model state and its register copies.
  phase_e      ph;
  logic [2:0]  cmd_l;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg, dly, rx_byte;
  logic [15:0] str_cnt;
  logic        started, arb, ack_l, scl_d, sda_d;
  logic [7:0]  half_ticks;
  logic [15:0] str_limit;

  // Line behavior of the simulated slave and bus.
  logic [7:0]  slave_byte;
  logic        slave_ack;
  int unsigned stretch_pct, arb_pct;
  bit          gaps_on, hold_rsp;

  // Expected line status, one per accepted tick, oldest first.
  result_t     status_due[$];

  int unsigned ticks_sent, checked, mismatches, cfg_writes, busy_drops;
  int unsigned arb_losses, limit_hits, input_stalls, quiet_cycles, rsp_stall;
  int unsigned finished[8];

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Counts one delay tick; true when the half-bit delay is over.
  function automatic bit delay_elapsed();
    dly = dly + 8'd1;
    if (dly >= half_ticks) begin
      dly = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One clock-stretch tick; true once SCL is high or the wait limit is hit.
  function automatic bit stretch_elapsed(logic scl);
    if (scl || str_cnt >= str_limit) begin
      if (!scl) limit_hits++;
      str_cnt = '0;
      return 1'b1;
    end
    str_cnt = str_cnt + 16'd1;
    return 1'b0;
  endfunction

  // Sets SDA for the next data or acknowledge bit.
  function automatic void enter_bit();
    if (bit_cnt < BYTE_BITS) sda_d = (cmd_l == REQ_WRITE) ? shreg[7] : 1'b1;
    else sda_d = (cmd_l == REQ_WRITE) ? 1'b1 : ~ack_l;
    dly = '0;
    ph  = PH_B_SETUP;
  endfunction

  // Advances the engine model by one tick and returns the line status after it.
  function automatic result_t engine_status_after(tick_t t);
    result_t r;
    logic    done;
    done = 1'b0;
    if (ph != PH_IDLE && t.code >= REQ_START && t.code <= REQ_READ) busy_drops++;
    case (ph)
      PH_IDLE: begin
        if (t.code >= REQ_START && t.code <= REQ_READ) begin
          cmd_l   = t.code;
          arb     = 1'b0;
          dly     = '0;
          str_cnt = '0;
          if (t.code == REQ_START) begin
            if (started) begin
              sda_d = 1'b1;
              ph    = PH_RS_SETUP;
            end else begin
              if (!t.sda) arb = 1'b1;
              sda_d = 1'b0;
              ph    = PH_ST_FALL;
            end
          end else if (t.code == REQ_STOP) begin
            sda_d = 1'b0;
            ph    = PH_SP_SETUP;
          end else begin
            bit_cnt = '0;
            if (t.code == REQ_WRITE) begin
              shreg = t.wdata;
              ack_l = 1'b0;
            end else begin
              shreg = '0;
              ack_l = t.acken;
            end
            enter_bit();
          end
        end
      end
      PH_RS_SETUP: begin
        if (delay_elapsed()) begin
          scl_d = 1'b1;
          ph    = PH_RS_STRETCH;
        end
      end
      PH_RS_STRETCH: begin
        if (stretch_elapsed(t.scl)) ph = PH_RS_HOLD;
      end
      PH_RS_HOLD: begin
        if (delay_elapsed()) begin
          if (!t.sda) arb = 1'b1;
          sda_d = 1'b0;
          ph    = PH_ST_FALL;
        end
      end
      PH_ST_FALL: begin
        if (delay_elapsed()) begin
          scl_d   = 1'b0;
          started = 1'b1;
          ph      = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_SP_SETUP: begin
        if (delay_elapsed()) begin
          scl_d = 1'b1;
          ph    = PH_SP_STRETCH;
        end
      end
      PH_SP_STRETCH: begin
        if (stretch_elapsed(t.scl)) ph = PH_SP_HOLD;
      end
      PH_SP_HOLD: begin
        if (delay_elapsed()) begin
          sda_d = 1'b1;
          ph    = PH_SP_RISE;
        end
      end
      PH_SP_RISE: begin
        if (delay_elapsed()) begin
          if (!t.sda) arb = 1'b1;
          ph = PH_SP_TAIL;
        end
      end
      PH_SP_TAIL: begin
        if (delay_elapsed()) begin
          started = 1'b0;
          ph      = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_B_SETUP: begin
        if (delay_elapsed()) begin
          scl_d = 1'b1;
          ph    = PH_B_STRETCH;
        end
      end
      PH_B_STRETCH: begin
        if (stretch_elapsed(t.scl)) ph = PH_B_HOLD;
      end
      PH_B_HOLD: begin
        if (delay_elapsed()) begin
          // Sample the bit: data, arbitration or acknowledge on a write, shift in or arbitration check on a read.
          if (cmd_l == REQ_WRITE) begin
            if (bit_cnt < BYTE_BITS) begin
              if (sda_d && !t.sda) arb = 1'b1;
              shreg = {shreg[6:0], 1'b0};
            end else begin
              ack_l = !t.sda && !arb;
            end
          end else begin
            if (bit_cnt < BYTE_BITS) begin
              shreg = {shreg[6:0], t.sda};
              if (bit_cnt == LAST_DATA_BIT) rx_byte = shreg;
            end else if (sda_d && !t.sda) begin
              arb = 1'b1;
            end
          end
          scl_d   = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt > BYTE_BITS) begin
            bit_cnt = '0;
            ph      = PH_IDLE;
            done    = 1'b1;
          end else begin
            enter_bit();
          end
        end
      end
      default: begin
        ph = PH_IDLE;
      end
    endcase
    if (done) begin
      finished[cmd_l]++;
      if (arb) arb_losses++;
    end
    r.scl_release = scl_d;
    r.sda_release = sda_d;
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = done;
    r.read_data   = rx_byte;
    r.ack_seen    = (cmd_l == REQ_WRITE) ? ack_l : 1'b0;
    r.arb_lost    = arb;
    r.bus_started = started;
    return r;
  endfunction

  // Builds the pin levels of one tick from the bus state, offers it and records its status.
  task automatic drive_tick(logic [2:0] code, logic [7:0] wdata, logic acken);
    tick_t       t;
    bit          in_bits;
    int          idx;
    int unsigned gap;
    t.code  = code;
    t.wdata = wdata;
    t.acken = acken;
    in_bits = (ph == PH_B_SETUP || ph == PH_B_STRETCH || ph == PH_B_HOLD);
    if (!scl_d) t.scl = roll(3);
    else if (ph == PH_RS_STRETCH || ph == PH_SP_STRETCH || ph == PH_B_STRETCH)
      t.scl = !roll(stretch_pct);
    else t.scl = !roll(3);
    if (!sda_d) begin
      t.sda = roll(2);
    end else if (in_bits && bit_cnt < BYTE_BITS && cmd_l == REQ_READ) begin
      idx   = LAST_DATA_BIT - bit_cnt;
      t.sda = slave_byte[idx];
    end else if (in_bits && bit_cnt == BYTE_BITS && cmd_l == REQ_WRITE) begin
      t.sda = !slave_ack;
    end else begin
      t.sda = !roll(arb_pct);
    end
    gap = (gaps_on && roll(20)) ? gap_length() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= t.code;
    req_if.write_data <= t.wdata;
    req_if.ack_enable <= t.acken;
    req_if.scl_in     <= t.scl;
    req_if.sda_in     <= t.sda;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
      input_stalls++;
    end
    status_due.push_back(engine_status_after(t));
    ticks_sent++;
  endtask

  // One tick while a command runs; now and then a command that must be dropped.
  task automatic busy_tick(int unsigned poke_pct);
    if (roll(poke_pct)) drive_tick(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
    else drive_tick(REQ_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Issues a command and ticks until the engine is idle again.
  task automatic do_command(logic [2:0] code, logic [7:0] wdata, logic acken, bit poke);
    drive_tick(code, wdata, acken);
    while (ph != PH_IDLE) busy_tick(poke ? 15 : 0);
  endtask

  // Brings the engine to idle and waits until every expected status has arrived.
  task automatic quiesce();
    while (ph != PH_IDLE) drive_tick(REQ_TICK, 8'($urandom), 1'($urandom));
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] value);
    quiesce();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_if.ready) break;
    end
    case (idx)
      CFG_HALF_BIT_TICKS: half_ticks = value[7:0];
      CFG_STRETCH_LIMIT:  str_limit = value;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] status %0d: %s is %0h, expected %0h", $time, checked, what, got, want);
  endtask

  // Reset values, then request codes that act as plain ticks.
  task automatic test_tick_codes();
    int c;
    drive_tick(REQ_TICK, 8'h00, 1'b0);
    for (c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++) drive_tick(3'(c), 8'hFF, 1'b1);
    drive_tick(REQ_TICK, 8'hFF, 1'b1);
  endtask

  // Stop and byte commands issued before any start.
  task automatic test_unstarted_commands();
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    slave_ack = 1'b1;
    do_command(REQ_WRITE, 8'hA5, 1'b0, 1'b0);
    slave_byte = 8'h3C;
    do_command(REQ_READ, 8'h00, 1'b1, 1'b0);
  endtask

  // Write and read extremes, ACK and NACK, repeated start, and commands while busy.
  task automatic test_byte_transfers();
    do_command(REQ_START, 8'h00, 1'b0, 1'b1);
    slave_ack = 1'b1;
    do_command(REQ_WRITE, 8'hFF, 1'b0, 1'b1);
    slave_ack = 1'b0;
    do_command(REQ_WRITE, 8'h00, 1'b1, 1'b0);
    slave_byte = 8'hFF;
    do_command(REQ_READ, 8'h00, 1'b1, 1'b1);
    slave_byte = 8'h00;
    do_command(REQ_READ, 8'hFF, 1'b0, 1'b0);
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    slave_ack = 1'b1;
    do_command(REQ_WRITE, 8'h5A, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b1);
  endtask

  // Released SDA seen low at the start check, in data bits, in the NACK and in the stop.
  task automatic test_arbitration();
    arb_pct = 100;
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    slave_ack = 1'b1;
    do_command(REQ_WRITE, 8'hFF, 1'b0, 1'b0);
    slave_byte = 8'hC3;
    do_command(REQ_READ, 8'h00, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    arb_pct = 0;
  endtask

  // Clock stretching with no wait allowed, cut at a small limit, and with the widest limit.
  task automatic test_clock_stretch();
    write_reg(CFG_STRETCH_LIMIT, 16'h0000);
    stretch_pct = 100;
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    do_command(REQ_WRITE, 8'h81, 1'b0, 1'b0);
    write_reg(CFG_STRETCH_LIMIT, 16'd3);
    do_command(REQ_READ, 8'h00, 1'b1, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    write_reg(CFG_STRETCH_LIMIT, 16'hFFFF);
    stretch_pct = 60;
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    do_command(REQ_WRITE, 8'h7E, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    stretch_pct = 0;
  endtask

  // Zero, shortest and longest half-bit delays; a write to an unused register index.
  task automatic test_delay_extremes();
    write_reg(CFG_HALF_BIT_TICKS, 16'd0);
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    slave_byte = 8'h69;
    do_command(REQ_READ, 8'h00, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    write_reg(CFG_HALF_BIT_TICKS, 16'd1);
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    do_command(REQ_WRITE, 8'h18, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    write_reg(CFG_HALF_BIT_TICKS, 16'd255);
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    do_command(REQ_WRITE, 8'h96, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    write_reg(CFG_UNUSED_IDX, 16'h0001);
    write_reg(CFG_HALF_BIT_TICKS, {8'h00, HALF_BIT_RESET});
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the input stalls.
  task automatic test_back_pressure();
    gaps_on  = 1'b0;
    hold_rsp = 1'b1;
    do_command(REQ_START, 8'h00, 1'b0, 1'b0);
    do_command(REQ_WRITE, 8'hE7, 1'b0, 1'b0);
    do_command(REQ_WRITE, 8'h24, 1'b0, 1'b0);
    do_command(REQ_STOP, 8'h00, 1'b0, 1'b0);
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed transfers with random content, some noise codes and dropped commands.
  task automatic random_transfers(int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      if (ph != PH_IDLE) begin
        busy_tick(8);
      end else begin
        r          = $urandom_range(0, 99);
        slave_ack  = roll(80);
        slave_byte = 8'($urandom);
        if (r < 8) drive_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
        else if (r < 20) drive_tick(REQ_TICK, 8'($urandom), 1'($urandom));
        else if (!started || r < 28) drive_tick(REQ_START, 8'($urandom), 1'($urandom));
        else if (r < 36) drive_tick(REQ_STOP, 8'($urandom), 1'($urandom));
        else if (r < 70) drive_tick(REQ_WRITE, 8'($urandom), 1'($urandom));
        else drive_tick(REQ_READ, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    int s;
    stretch_pct = 35;
    arb_pct     = 4;
    for (s = 0; s < 5; s++) begin
      case (s)
        0: begin
          write_reg(CFG_HALF_BIT_TICKS, 16'd1);
          write_reg(CFG_STRETCH_LIMIT, 16'd0);
        end
        1: begin
          write_reg(CFG_HALF_BIT_TICKS, 16'd2);
          write_reg(CFG_STRETCH_LIMIT, 16'd5);
        end
        2: begin
          write_reg(CFG_HALF_BIT_TICKS, 16'd0);
          write_reg(CFG_STRETCH_LIMIT, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_HALF_BIT_TICKS, 16'd3);
          write_reg(CFG_STRETCH_LIMIT, 16'd30);
        end
        default: begin
          write_reg(CFG_HALF_BIT_TICKS, 16'($urandom_range(1, 6)));
          write_reg(CFG_STRETCH_LIMIT, 16'($urandom_range(0, 40)));
        end
      endcase
      gaps_on = (s != 0);
      random_transfers(280);
    end
    gaps_on = 1'b1;
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    rsp_if.ready = 1'b0;
    rsp_stall    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_stall = HOLD_OFF_CYCLES;
        hold_rsp  = 1'b0;
      end else if (rsp_stall == 0 && gaps_on && roll(20)) begin
        rsp_stall = gap_length();
      end
      if (rsp_stall > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result item with the oldest expected status.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = status_due.pop_front();
        if (rsp_if.scl_release !== want.scl_release)
          report_mismatch("scl_release", rsp_if.scl_release, want.scl_release);
        if (rsp_if.sda_release !== want.sda_release)
          report_mismatch("sda_release", rsp_if.sda_release, want.sda_release);
        if (rsp_if.busy_res !== want.busy_res)
          report_mismatch("busy_res", rsp_if.busy_res, want.busy_res);
        if (rsp_if.done_res !== want.done_res)
          report_mismatch("done_res", rsp_if.done_res, want.done_res);
        if (rsp_if.read_data !== want.read_data)
          report_mismatch("read_data", rsp_if.read_data, want.read_data);
        if (rsp_if.ack_seen !== want.ack_seen)
          report_mismatch("ack_seen", rsp_if.ack_seen, want.ack_seen);
        if (rsp_if.arb_lost !== want.arb_lost)
          report_mismatch("arb_lost", rsp_if.arb_lost, want.arb_lost);
        if (rsp_if.bus_started !== want.bus_started)
          report_mismatch("bus_started", rsp_if.bus_started, want.bus_started);
      end
      checked++;
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_TICK;
    req_if.write_data = '0;
    req_if.ack_enable = 1'b0;
    req_if.scl_in     = 1'b1;
    req_if.sda_in     = 1'b1;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_HALF_BIT_TICKS;
    cfg_if.data       = '0;
    ph          = PH_IDLE;
    cmd_l       = '0;
    bit_cnt     = '0;
    shreg       = '0;
    dly         = '0;
    rx_byte     = '0;
    str_cnt     = '0;
    started     = 1'b0;
    arb         = 1'b0;
    ack_l       = 1'b0;
    scl_d       = 1'b1;
    sda_d       = 1'b1;
    half_ticks  = HALF_BIT_RESET;
    str_limit   = STRETCH_RESET;
    slave_byte  = '0;
    slave_ack   = 1'b1;
    stretch_pct = 0;
    arb_pct     = 0;
    gaps_on     = 1'b1;
    hold_rsp    = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_tick_codes();
    test_unstarted_commands();
    test_byte_transfers();
    test_arbitration();
    test_clock_stretch();
    test_delay_extremes();
    test_back_pressure();
    test_random_traffic();
    quiesce();

    $display("Covered %0d ticks, %0d register writes; finished %0d start, %0d stop, %0d write,",
             ticks_sent, cfg_writes, finished[REQ_START], finished[REQ_STOP],
             finished[REQ_WRITE]);
    $display("%0d read; %0d dropped busy, %0d arb losses, %0d stretch cuts, %0d input stalls.",
             finished[REQ_READ], busy_drops, arb_losses, limit_hits, input_stalls);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
